// ----- rtl/fcm_pkg.sv -----
// Shared constants and types for the framed command matcher.
`timescale 1ns / 1ps
package fcm_pkg;

  localparam int BUFFER_BYTES = 37;
  localparam int KEY_BYTES    = 6;
  localparam int PREFIX_BYTES = 4;

  // Window holds just the leading bytes that any compare looks at.
  localparam int WIN_DEPTH = (KEY_BYTES > PREFIX_BYTES) ? KEY_BYTES : PREFIX_BYTES;
  localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int POS_W     = 6;

  localparam int BYTE_W    = 8;
  localparam int CLASS_W   = 2;
  localparam int KEY_W     = 48;
  localparam int PREFIX_W  = 32;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [CLASS_W-1:0]  class_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam byte_t OPEN_BYTE  = 8'h3C;
  localparam byte_t CLOSE_BYTE = 8'h3E;
  localparam byte_t FILL_BYTE  = 8'h40;

  localparam logic [KEY_W-1:0]    OWN_KEY_RST      = 48'h53454E444331;
  localparam logic [PREFIX_W-1:0] CHILD_PREFIX_RST = 32'h44544334;

  localparam cfg_idx_t CFG_OWN_KEY      = 1'b0;
  localparam cfg_idx_t CFG_CHILD_PREFIX = 1'b1;

  localparam class_t CLASS_OWN_KEY = 2'd0;
  localparam class_t CLASS_CHILD   = 2'd1;
  localparam class_t CLASS_OTHER   = 2'd2;

  localparam pos_t POS_LAST = pos_t'(BUFFER_BYTES - 1);

endpackage

// ----- rtl/fcm_in_if.sv -----
// Input channel: one received byte per word.
`timescale 1ns / 1ps
interface fcm_in_if;
  logic          valid;
  logic          ready;
  fcm_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/fcm_out_if.sv -----
// Result channel: message class and frame length per word.
`timescale 1ns / 1ps
interface fcm_out_if;
  logic            valid;
  logic            ready;
  fcm_pkg::class_t msg_class;
  fcm_pkg::pos_t   frame_length;

  modport source (output valid, output msg_class, output frame_length, input ready);
  modport sink   (input valid, input msg_class, input frame_length, output ready);
endinterface

// ----- rtl/framed_command_matcher_top.sv -----
// Framed command matcher: frame tracking, key window and class compare.
// A closing '>' word shows its result in the cycle after it is accepted.
// Throughput: one input word per cycle while the result slot is free or being
// drained; the output register accepts a new result in the same cycle that the previous one is taken.
// Reset (rst_n low, synchronous): leave the frame, clear the position,
// fill the key window with '@', reload the key and prefix reset values.
`timescale 1ns / 1ps
module framed_command_matcher_top (
  input  logic                       clk,
  input  logic                       rst_n,
  fcm_in_if.sink                     in_ch,
  fcm_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  fcm_pkg::cfg_idx_t          cfg_index,
  input  logic [fcm_pkg::CFG_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [fcm_pkg::KEY_W-1:0]    own_key_r;
  logic [fcm_pkg::PREFIX_W-1:0] child_prefix_r;

  // Frame state.
  logic                in_frame_r, in_frame_nxt;
  fcm_pkg::pos_t       pos_r, pos_nxt;
  fcm_pkg::byte_t      win_r   [fcm_pkg::WIN_DEPTH];
  fcm_pkg::byte_t      win_nxt [fcm_pkg::WIN_DEPTH];

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  fcm_pkg::class_t     out_class_r, out_class_nxt;
  fcm_pkg::pos_t       out_len_r, out_len_nxt;

  logic                in_accept;
  logic                key_hit, prefix_hit;

  // Take a word whenever the result slot is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.msg_class    = out_class_r;
  assign out_ch.frame_length = out_len_r;

  // Byte-wise compare of the window against key and prefix, first byte high.
  always_comb begin
    key_hit    = 1'b1;
    prefix_hit = 1'b1;
    for (int i = 0; i < fcm_pkg::KEY_BYTES; i++) begin
      if (win_r[i] != own_key_r[8*(fcm_pkg::KEY_BYTES-1-i) +: 8]) begin
        key_hit = 1'b0;
      end
    end
    for (int i = 0; i < fcm_pkg::PREFIX_BYTES; i++) begin
      if (win_r[i] != child_prefix_r[8*(fcm_pkg::PREFIX_BYTES-1-i) +: 8]) begin
        prefix_hit = 1'b0;
      end
    end
  end

  // Frame tracking and result capture.
  always_comb begin
    in_frame_nxt  = in_frame_r;
    pos_nxt       = pos_r;
    win_nxt       = win_r;
    out_class_nxt = out_class_r;
    out_len_nxt   = out_len_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (in_accept) begin
      if (!in_frame_r) begin
        // Outside a frame: only '<' matters, everything else is dropped.
        if (in_ch.rx_byte == fcm_pkg::OPEN_BYTE) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = '0;
        end
      end else if (in_ch.rx_byte != fcm_pkg::CLOSE_BYTE) begin
        // Store leading bytes only; later positions just advance, wrapping to zero after the last slot.
        if (pos_r < fcm_pkg::pos_t'(fcm_pkg::WIN_DEPTH)) begin
          win_nxt[pos_r[fcm_pkg::WIN_IDX_W-1:0]] = in_ch.rx_byte;
        end
        pos_nxt = (pos_r == fcm_pkg::POS_LAST) ? '0 : pos_r + 1'b1;
      end else begin
        // Close: classify, then refill the window and leave the frame.
        out_valid_nxt = 1'b1;
        out_len_nxt   = pos_r;
        if (key_hit) begin
          out_class_nxt = fcm_pkg::CLASS_OWN_KEY;
        end else if (prefix_hit) begin
          out_class_nxt = fcm_pkg::CLASS_CHILD;
        end else begin
          out_class_nxt = fcm_pkg::CLASS_OTHER;
        end
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        for (int i = 0; i < fcm_pkg::WIN_DEPTH; i++) begin
          win_nxt[i] = fcm_pkg::FILL_BYTE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < fcm_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= fcm_pkg::FILL_BYTE;
      end
    end else begin
      in_frame_r  <= in_frame_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
    out_len_r   <= out_len_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_key_r      <= fcm_pkg::OWN_KEY_RST;
      child_prefix_r <= fcm_pkg::CHILD_PREFIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fcm_pkg::CFG_OWN_KEY: begin
          own_key_r <= cfg_data[fcm_pkg::KEY_W-1:0];
        end
        fcm_pkg::CFG_CHILD_PREFIX: begin
          child_prefix_r <= cfg_data[fcm_pkg::PREFIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // Position never runs past the last buffer slot.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= fcm_pkg::POS_LAST)
    else $error("write position out of range");

  // Outside a frame the position sits at zero.
  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> pos_r == '0)
    else $error("position not cleared outside a frame");

  // A new result follows only an accepted close byte inside a frame.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !(in_frame_r && in_ch.rx_byte == fcm_pkg::CLOSE_BYTE))
      |=> !out_valid_r || $past(out_valid_r && !out_ch.ready))
    else $error("result without a closing byte");

  // A frame close always leaves the frame.
  a_close_exits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_frame_r && in_ch.rx_byte == fcm_pkg::CLOSE_BYTE)
      |=> !in_frame_r && out_valid_r)
    else $error("frame close not handled");
`endif

endmodule
